// ===== rtl/madt_entry_parser_assert.svh =====
`ifndef MADT_ENTRY_PARSER_ASSERT_SVH
`define MADT_ENTRY_PARSER_ASSERT_SVH
// Assertion helpers used by the MADT entry parser.
`define MADT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("madt assertion failed");
`define MADT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("madt assertion failed");
`endif

// ===== rtl/madt_pkg.sv =====
package madt_pkg;

	localparam int unsigned MaxCpusDef      = 16;
	localparam int unsigned MaxOverridesDef = 16;
	localparam logic [31:0] HdrLen          = 32'd44;

	localparam logic [2:0] KIND_CPU     = 3'd0;
	localparam logic [2:0] KIND_IOAPIC  = 3'd1;
	localparam logic [2:0] KIND_OVR     = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN = 3'd3;
	localparam logic [2:0] KIND_END     = 3'd4;
	localparam logic [2:0] KIND_REMAP   = 3'd5;
	localparam logic [2:0] KIND_MALFORM = 3'd6;

	localparam logic [7:0] REC_CPU    = 8'd0;
	localparam logic [7:0] REC_IOAPIC = 8'd1;
	localparam logic [7:0] REC_OVR    = 8'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] table_byte;
		logic       first_byte;
		logic [7:0] irq_number;
	} madt_in_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [3:0]  cpu_slot;
		logic        cpu_accepted;
		logic [7:0]  apic_id;
		logic [31:0] io_apic_address;
		logic [7:0]  override_source;
		logic [31:0] interrupt_number;
		logic [31:0] local_apic_address;
		logic [7:0]  unknown_type;
		logic [4:0]  cpu_total;
		logic        override_dropped;
		logic        last_of_run;
	} madt_out_t;

endpackage

// ===== rtl/madt_entry_parser.sv =====
// MADT entry parser. Bytes of an ACPI MADT table arrive one per transfer on
// in_*; processor, I/O APIC, override, unknown, table end, malformed and
// remap results leave on out_*, and a byte that ends a record and the table
// gives two results. A table byte is captured in ST_IDLE and decoded in
// ST_BYTE, and its results are held in ST_OUT and ST_OUT2. A remap query
// compares one stored override per cycle through a single compare unit and
// stops at the first match or after the last stored one. The block accepts
// no new item until all results of the previous one are taken.
module madt_entry_parser #(
	parameter int unsigned MAX_CPUS      = madt_pkg::MaxCpusDef,
	parameter int unsigned MAX_OVERRIDES = madt_pkg::MaxOverridesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  madt_pkg::madt_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output madt_pkg::madt_out_t out_data
);
	import madt_pkg::*;

	localparam int unsigned CW = $clog2(MAX_CPUS + 1);
	localparam int unsigned OW = $clog2(MAX_OVERRIDES + 1);
	localparam int unsigned IW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BYTE  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_OUT   = 3'd3;
	localparam logic [2:0] ST_OUT2  = 3'd4;

	logic [2:0]  state_q;
	madt_in_t    req_q;
	logic [31:0] offset_q, size_q, lapic_q, word_q;
	logic [7:0]  pos_q, kind_q, esize_q, id_q;
	logic        stopped_q;
	logic [CW-1:0] cpu_q;
	logic [OW-1:0] ovr_q;
	logic [OW-1:0] walk_q;
	logic [7:0]    src_mem [MAX_OVERRIDES];
	logic [31:0]   tgt_mem [MAX_OVERRIDES];
	logic [7:0]    src_rd_q;
	logic [31:0]   tgt_rd_q;
	logic          rd_ok_q;
	madt_out_t   res_q, res2_q;
	logic        two_q;

	logic [31:0]   b32, o, o_n, tsz_n, lap_n, wrd_n, fwd;
	logic [7:0]    b, fid, pos_n;
	logic          first, active, hdr, malformed, hdr_end, fin, tbl_end;
	logic          st_wr, cpu_take, walk_hit;
	logic [CW-1:0] cpu_n;
	logic [OW-1:0] ovr_n;
	madt_out_t     rec_res, end_res, mal_res, rmp_res;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT) || (state_q == ST_OUT2);
	assign out_data  = (state_q == ST_OUT2) ? res2_q : res_q;

	function automatic madt_out_t blank(input logic [2:0] k, input logic [CW-1:0] c);
		madt_out_t f;
		f = '0;
		f.result_kind = k;
		f.cpu_total   = 5'(c);
		return f;
	endfunction

	// Byte decode, evaluated in ST_BYTE from the held request.
	always_comb begin
		b      = req_q.table_byte;
		b32    = {24'd0, b};
		first  = req_q.first_byte;
		active = first || !stopped_q;
		o      = first ? 32'd0 : offset_q;
		o_n    = o + 32'd1;
		hdr    = o < HdrLen;
		tsz_n  = first ? 32'd0 : size_q;
		lap_n  = first ? 32'd0 : lapic_q;
		if (o >= 32'd4 && o < 32'd8)
			tsz_n = tsz_n | (b32 << {o[1:0], 3'b000});
		if (o >= 32'd36 && o < 32'd40)
			lap_n = lap_n | (b32 << {o[1:0], 3'b000});
		wrd_n = word_q;
		if (pos_q >= 8'd4 && pos_q <= 8'd7)
			wrd_n = word_q | (b32 << {pos_q[1:0], 3'b000});
	end

	// Record and table decisions.
	always_comb begin
		malformed = 1'b0;
		hdr_end   = 1'b0;
		fin       = 1'b0;
		fid       = id_q;
		fwd       = wrd_n;
		if (active) begin
			if (hdr) begin
				malformed = (o == 32'd7) && (tsz_n < HdrLen);
				hdr_end   = (o == HdrLen - 32'd1) && (tsz_n == HdrLen);
			end else if (pos_q == 8'd0) begin
				malformed = ({1'b0, o} + 33'd2) > {1'b0, size_q};
			end else if (pos_q == 8'd1) begin
				malformed = (b < 8'd2) ||
				            (({1'b0, o - 32'd1} + {25'd0, b}) > {1'b0, size_q});
				fin = !malformed && (b == 8'd2);
				fid = 8'd0;
				fwd = 32'd0;
			end else begin
				if (pos_q == 8'd3) fid = b;
				fin = ({1'b0, pos_q} + 9'd1) >= {1'b0, esize_q};
			end
		end
		tbl_end  = fin && (o_n == tsz_n);
		cpu_take = cpu_q < CW'(MAX_CPUS);
		st_wr    = fin && kind_q == REC_OVR && ovr_q < OW'(MAX_OVERRIDES);
		cpu_n    = (fin && kind_q == REC_CPU && cpu_take) ? cpu_q + CW'(1) : cpu_q;
		ovr_n    = first ? '0 : (st_wr ? ovr_q + OW'(1) : ovr_q);
		pos_n    = first ? 8'd0 : pos_q;
		if (active && !hdr && !malformed)
			pos_n = fin ? 8'd0 : pos_q + 8'd1;

		unique case (kind_q)
			REC_CPU: begin
				rec_res = blank(KIND_CPU, cpu_n);
				rec_res.apic_id = fid;
				if (cpu_take) begin
					rec_res.cpu_slot = 4'(cpu_q);
					rec_res.cpu_accepted = 1'b1;
				end
			end
			REC_IOAPIC: begin
				rec_res = blank(KIND_IOAPIC, cpu_q);
				rec_res.io_apic_address = fwd;
			end
			REC_OVR: begin
				rec_res = blank(KIND_OVR, cpu_q);
				rec_res.override_source = fid;
				rec_res.interrupt_number = fwd;
				rec_res.override_dropped = !(ovr_q < OW'(MAX_OVERRIDES));
			end
			default: begin
				rec_res = blank(KIND_UNKNOWN, cpu_q);
				rec_res.unknown_type = kind_q;
			end
		endcase
		rec_res.last_of_run = !tbl_end;

		end_res = blank(KIND_END, cpu_n);
		end_res.local_apic_address = lap_n;
		end_res.last_of_run = 1'b1;

		mal_res = blank(KIND_MALFORM, cpu_q);
		mal_res.last_of_run = 1'b1;

		// Compare unit sees the entry read last cycle.
		walk_hit = rd_ok_q && (src_rd_q == req_q.irq_number);
		rmp_res = blank(KIND_REMAP, cpu_q);
		rmp_res.interrupt_number = walk_hit ? tgt_rd_q : {24'd0, req_q.irq_number};
		rmp_res.last_of_run = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && walk_q < ovr_q) begin
			src_rd_q <= src_mem[walk_q[IW-1:0]];
			tgt_rd_q <= tgt_mem[walk_q[IW-1:0]];
		end
		if (state_q == ST_BYTE && st_wr) begin
			src_mem[ovr_q[IW-1:0]] <= fid;
			tgt_mem[ovr_q[IW-1:0]] <= fwd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			req_q     <= '0;
			offset_q  <= '0;
			size_q    <= '0;
			lapic_q   <= '0;
			pos_q     <= '0;
			kind_q    <= '0;
			esize_q   <= '0;
			id_q      <= '0;
			word_q    <= '0;
			stopped_q <= 1'b1;
			cpu_q     <= '0;
			ovr_q     <= '0;
			walk_q    <= '0;
			rd_ok_q   <= 1'b0;
			res_q     <= '0;
			res2_q    <= '0;
			two_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						walk_q  <= '0;
						rd_ok_q <= 1'b0;
						state_q <= in_data.req_type ? ST_WALK : ST_BYTE;
					end
				end
				ST_WALK: begin
					if (walk_hit || walk_q >= ovr_q) begin
						res_q   <= rmp_res;
						two_q   <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						rd_ok_q <= 1'b1;
						walk_q  <= walk_q + OW'(1);
					end
				end
				ST_BYTE: begin
					if (active) begin
						stopped_q <= malformed || hdr_end || tbl_end;
						offset_q  <= o_n;
						size_q    <= tsz_n;
						lapic_q   <= lap_n;
					end
					if (active && !hdr && !malformed) begin
						if (pos_q == 8'd0) begin
							kind_q <= b;
							id_q   <= '0;
							word_q <= '0;
						end else begin
							id_q   <= fid;
							word_q <= fwd;
							if (pos_q == 8'd1) esize_q <= b;
						end
					end
					pos_q <= pos_n;
					ovr_q <= ovr_n;
					cpu_q <= cpu_n;
					if (malformed) begin
						res_q   <= mal_res;
						two_q   <= 1'b0;
						state_q <= ST_OUT;
					end else if (hdr_end) begin
						res_q   <= end_res;
						two_q   <= 1'b0;
						state_q <= ST_OUT;
					end else if (fin) begin
						res_q   <= rec_res;
						res2_q  <= end_res;
						two_q   <= tbl_end;
						state_q <= ST_OUT;
					end else begin
						two_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ready) state_q <= two_q ? ST_OUT2 : ST_IDLE;
				end
				ST_OUT2: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "madt_entry_parser_assert.svh"
	`MADT_ASSERT_IMPL(a_no_accept_busy, state_q != ST_IDLE, !in_ready)
	`MADT_ASSERT_IMPL(a_ovr_bound, 1'b1, ovr_q <= OW'(MAX_OVERRIDES))
	`MADT_ASSERT_IMPL(a_cpu_bound, 1'b1, cpu_q <= CW'(MAX_CPUS))
	`MADT_ASSERT_NEXT(a_second_follows, state_q == ST_OUT && out_ready && two_q,
		state_q == ST_OUT2)

endmodule
